// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, muted while reset is asserted
`define CHK_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("odometry check failed");

// concurrent check that also holds through reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("odometry check failed");

`endif

// ===== src/ddo_pkg.sv =====
package ddo_pkg;

  // register indexes of the configuration port
  localparam logic RegDistPerTick = 1'b0;
  localparam logic RegInvWheelBase = 1'b1;

  localparam logic [23:0] DistPerTickRst = 24'd212336;
  localparam logic [23:0] InvWheelBaseRst = 24'd158275;

  // queue between front and back
  localparam int QDepth = 8;
  localparam int QAw = $clog2(QDepth);

  // divider: magnitude of (dl8 + dr8) * 4096
  localparam int NumW = 46;
  localparam int DenW = 16;

  // angles in q28, cordic datapath
  localparam logic signed [33:0] PiQ28 = 34'sd843314857;
  localparam logic signed [33:0] TwoPiQ28 = 34'sd1686629713;
  localparam logic signed [33:0] HalfPiQ28 = 34'sd421657428;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;

  typedef struct packed {
    logic signed [32:0] dl8;
    logic signed [32:0] dr8;
    logic signed [15:0] hd;
    logic signed [15:0] dth;
  } mid_t;

  typedef struct packed {
    logic               zero;
    logic signed [31:0] dxz;
    logic signed [15:0] dth;
    logic signed [16:0] ang1;
    logic signed [16:0] ang2;
    logic               neg;
  } carry_t;

  // atan(2^-i) in q28, rounded to nearest
  function automatic logic signed [33:0] atan_q28(input int unsigned i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd210828714;
      1: r = 34'sd124459457;
      2: r = 34'sd65760959;
      3: r = 34'sd33381290;
      4: r = 34'sd16755422;
      5: r = 34'sd8385879;
      6: r = 34'sd4193963;
      7: r = 34'sd2097109;
      8: r = 34'sd1048571;
      9: r = 34'sd524287;
      default: r = 34'sd1 <<< (28 - i);
    endcase
    return r;
  endfunction

endpackage

// ===== src/ddo_front.sv =====
module ddo_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic signed [15:0] left_ticks_i,
  input  logic signed [15:0] right_ticks_i,
  input  logic signed [15:0] heading_i,
  input  logic [23:0]        dpt_i,
  input  logic [23:0]        ibw_i,
  output logic               out_valid_o,
  output ddo_pkg::mid_t      out_item_o,
  output logic [2:0]         inflight_o
);
  import ddo_pkg::*;

  logic [3:0] v_q;

  logic signed [40:0] pl_d, pr_d, pl_q, pr_q;
  logic signed [15:0] hd1_q, hd2_q, hd3_q;
  logic signed [32:0] dl2_d, dr2_d, dl2_q, dr2_q, dl3_q, dr3_q;
  logic signed [33:0] diff_d;
  logic [40:0]        lo_d, lo_q;
  logic signed [41:0] hi_d, hi_q;
  logic signed [59:0] prod_d, rnd_d;
  logic signed [15:0] dth_d;
  mid_t               item_q;

  // wheel distances, exact in q16
  assign pl_d = left_ticks_i * $signed({1'b0, dpt_i});
  assign pr_d = right_ticks_i * $signed({1'b0, dpt_i});

  // round to q8
  assign dl2_d = 33'((pl_q + 41'sd128) >>> 8);
  assign dr2_d = 33'((pr_q + 41'sd128) >>> 8);

  // heading change product split in two partial products
  assign diff_d = 34'(dl2_q) - 34'(dr2_q);
  assign lo_d = 41'(diff_d[16:0]) * 41'(ibw_i);
  assign hi_d = 42'($signed(diff_d[33:17])) * $signed({18'b0, ibw_i});

  always_comb begin
    prod_d = (60'(hi_q) <<< 17) + 60'($signed({1'b0, lo_q}));
    rnd_d = (prod_d + 60'sd262144) >>> 19;
    if (rnd_d > 60'sd32767) begin
      dth_d = 16'sh7fff;
    end else if (rnd_d < -60'sd32768) begin
      dth_d = 16'sh8000;
    end else begin
      dth_d = rnd_d[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q <= pl_d;
    pr_q <= pr_d;
    hd1_q <= heading_i;
    dl2_q <= dl2_d;
    dr2_q <= dr2_d;
    hd2_q <= hd1_q;
    lo_q <= lo_d;
    hi_q <= hi_d;
    dl3_q <= dl2_q;
    dr3_q <= dr2_q;
    hd3_q <= hd2_q;
    item_q.dl8 <= dl3_q;
    item_q.dr8 <= dr3_q;
    item_q.hd <= hd3_q;
    item_q.dth <= dth_d;
  end

  assign out_valid_o = v_q[3];
  assign out_item_o = item_q;
  assign inflight_o = 3'(v_q[0]) + 3'(v_q[1]) + 3'(v_q[2]) + 3'(v_q[3]);

endmodule

// ===== src/ddo_queue.sv =====
module ddo_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  ddo_pkg::mid_t        wr_item_i,
  input  logic                 rd_i,
  output ddo_pkg::mid_t        rd_item_o,
  output logic                 empty_o,
  output logic [ddo_pkg::QAw:0] count_o
);
  import ddo_pkg::*;

  mid_t           mem_q [QDepth];
  logic [QAw-1:0] wp_q, rp_q;
  logic [QAw:0]   cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (rd_i) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wr_item_i;
    end
  end

  assign rd_item_o = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

// ===== src/ddo_divider.sv =====
module ddo_divider (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [ddo_pkg::NumW-1:0]  num_i,
  input  logic [ddo_pkg::DenW-1:0]  den_i,
  input  ddo_pkg::carry_t           car_i,
  output logic [ddo_pkg::NumW-1:0]  quo_o,
  output ddo_pkg::carry_t           car_o
);
  import ddo_pkg::*;

  // one quotient bit per stage, restoring
  logic [DenW:0]   rem_q [NumW];
  logic [NumW-1:0] rq_q  [NumW];
  logic [DenW-1:0] den_q [NumW];
  carry_t          car_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [DenW:0]   rem_s, trial, rem_d;
    logic [NumW-1:0] rq_s, rq_d;
    logic [DenW-1:0] den_s;
    carry_t          car_s;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_s = '0;
      assign rq_s = num_i;
      assign den_s = den_i;
      assign car_s = car_i;
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign rq_s = rq_q[k-1];
      assign den_s = den_q[k-1];
      assign car_s = car_q[k-1];
    end

    always_comb begin
      trial = {rem_s[DenW-1:0], rq_s[NumW-1]};
      ge = (trial >= {1'b0, den_s});
      rem_d = ge ? trial - {1'b0, den_s} : trial;
      rq_d = {rq_s[NumW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        rq_q[k] <= rq_d;
        den_q[k] <= den_s;
        car_q[k] <= car_s;
      end
    end
  end

  assign quo_o = rq_q[NumW-1];
  assign car_o = car_q[NumW-1];

endmodule

// ===== src/ddo_cordic.sv =====
module ddo_cordic #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [16:0] ang_i,
  output logic signed [33:0] sin_o,
  output logic signed [33:0] cos_o
);
  import ddo_pkg::*;

  logic signed [33:0] a_d, aw_d, aw_q;
  logic signed [33:0] x_q [CORDIC_ITERATIONS+1];
  logic signed [33:0] y_q [CORDIC_ITERATIONS+1];
  logic signed [33:0] z_q [CORDIC_ITERATIONS+1];
  logic               flip_q [CORDIC_ITERATIONS+1];
  logic signed [33:0] z0_d;
  logic               flip0_d;

  // q13 to q28, wrap into [-pi, pi]
  always_comb begin
    a_d = 34'(ang_i) <<< 15;
    if (a_d > PiQ28) begin
      aw_d = a_d - TwoPiQ28;
    end else if (a_d < -PiQ28) begin
      aw_d = a_d + TwoPiQ28;
    end else begin
      aw_d = a_d;
    end
  end

  // fold into [-pi/2, pi/2], cosine sign flips
  always_comb begin
    flip0_d = 1'b1;
    if (aw_q > HalfPiQ28) begin
      z0_d = PiQ28 - aw_q;
    end else if (aw_q < -HalfPiQ28) begin
      z0_d = -PiQ28 - aw_q;
    end else begin
      z0_d = aw_q;
      flip0_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aw_q <= aw_d;
      x_q[0] <= GainQ30;
      y_q[0] <= '0;
      z_q[0] <= z0_d;
      flip_q[0] <= flip0_d;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_iter
    logic signed [33:0] xs, ys, x_d, y_d, z_d;

    always_comb begin
      xs = x_q[i] >>> i;
      ys = y_q[i] >>> i;
      if (!z_q[i][33]) begin
        x_d = x_q[i] - ys;
        y_d = y_q[i] + xs;
        z_d = z_q[i] - atan_q28(i);
      end else begin
        x_d = x_q[i] + ys;
        y_d = y_q[i] - xs;
        z_d = z_q[i] + atan_q28(i);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1] <= x_d;
        y_q[i+1] <= y_d;
        z_q[i+1] <= z_d;
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  assign sin_o = y_q[CORDIC_ITERATIONS];
  assign cos_o = flip_q[CORDIC_ITERATIONS] ? -x_q[CORDIC_ITERATIONS] : x_q[CORDIC_ITERATIONS];

endmodule

// ===== src/ddo_back.sv =====
module ddo_back #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  ddo_pkg::mid_t      in_item_i,
  output logic               ready_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic signed [31:0] delta_x_o,
  output logic signed [31:0] delta_y_o,
  output logic signed [15:0] delta_heading_o
);
  import ddo_pkg::*;

  localparam int CorLat = CORDIC_ITERATIONS + 2;
  localparam int TotLat = 1 + NumW + CorLat + 3;

  logic              en;
  logic [TotLat-1:0] vld_q;

  // issue stage
  logic signed [33:0] sum_d;
  logic signed [46:0] num_d;
  logic signed [16:0] dth_w;
  logic [NumW-1:0]    nmag_d, nmag_q;
  logic [DenW-1:0]    dmag_d, dmag_q;
  carry_t             car_d, car0_q;

  logic [NumW-1:0]    quo;
  carry_t             car_dv;
  logic signed [33:0] s1, c1, s2, c2;

  logic signed [46:0] r8_q  [CorLat];
  carry_t             carc_q [CorLat];

  logic signed [34:0] sdw_d, cdw_d;
  logic signed [20:0] sd_q, cd_q;
  logic signed [46:0] r8p_q;
  carry_t             carp_q, carm_q;

  logic signed [45:0] lox_d, loy_d, lox_q, loy_q;
  logic signed [43:0] hix_d, hiy_d, hix_q, hiy_q;

  logic signed [67:0] px_d, py_d, tx_d, ty_d;
  logic signed [31:0] satx_d, saty_d;
  logic signed [31:0] dx_q, dy_q;
  logic signed [15:0] dh_q;

  assign en = !vld_q[TotLat-1] || pop_i;
  assign ready_o = en;

  always_comb begin
    sum_d = 34'(in_item_i.dl8) + 34'(in_item_i.dr8);
    num_d = 47'(sum_d) <<< 12;
    nmag_d = num_d[46] ? 46'(-num_d) : 46'(num_d);
    dth_w = 17'(in_item_i.dth);
    dmag_d = dth_w[16] ? 16'(-dth_w) : 16'(dth_w);
    car_d.zero = (in_item_i.dth == '0);
    if (in_item_i.dl8 > 33'sd2147483647) begin
      car_d.dxz = 32'sh7fffffff;
    end else if (in_item_i.dl8 < -33'sd2147483648) begin
      car_d.dxz = 32'sh80000000;
    end else begin
      car_d.dxz = in_item_i.dl8[31:0];
    end
    car_d.dth = in_item_i.dth;
    car_d.ang1 = 17'(in_item_i.hd);
    car_d.ang2 = 17'(in_item_i.hd) + dth_w;
    car_d.neg = num_d[46] ^ in_item_i.dth[15];
  end

  ddo_divider u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nmag_q),
    .den_i (dmag_q),
    .car_i (car0_q),
    .quo_o (quo),
    .car_o (car_dv)
  );

  ddo_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cor1 (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (car_dv.ang1),
    .sin_o (s1),
    .cos_o (c1)
  );

  ddo_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cor2 (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (car_dv.ang2),
    .sin_o (s2),
    .cos_o (c2)
  );

  // differences rounded to q16
  assign sdw_d = (35'(s1) - 35'(s2) + 35'sd8192) >>> 14;
  assign cdw_d = (35'(c1) - 35'(c2) + 35'sd8192) >>> 14;

  // radius times difference, two partial products per lane
  assign lox_d = $signed({1'b0, r8p_q[23:0]}) * sd_q;
  assign hix_d = $signed(r8p_q[46:24]) * sd_q;
  assign loy_d = $signed({1'b0, r8p_q[23:0]}) * cd_q;
  assign hiy_d = $signed(r8p_q[46:24]) * cd_q;

  always_comb begin
    px_d = (68'(hix_q) <<< 24) + 68'(lox_q);
    py_d = (68'(hiy_q) <<< 24) + 68'(loy_q);
    tx_d = (px_d + 68'sd32768) >>> 16;
    ty_d = (py_d + 68'sd32768) >>> 16;
    if (tx_d > 68'sd2147483647) begin
      satx_d = 32'sh7fffffff;
    end else if (tx_d < -68'sd2147483648) begin
      satx_d = 32'sh80000000;
    end else begin
      satx_d = tx_d[31:0];
    end
    if (ty_d > 68'sd2147483647) begin
      saty_d = 32'sh7fffffff;
    end else if (ty_d < -68'sd2147483648) begin
      saty_d = 32'sh80000000;
    end else begin
      saty_d = ty_d[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TotLat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nmag_q <= nmag_d;
      dmag_q <= dmag_d;
      car0_q <= car_d;
      r8_q[0] <= car_dv.neg ? -47'({1'b0, quo}) : 47'({1'b0, quo});
      carc_q[0] <= car_dv;
      for (int k = 1; k < CorLat; k++) begin
        r8_q[k] <= r8_q[k-1];
        carc_q[k] <= carc_q[k-1];
      end
      sd_q <= sdw_d[20:0];
      cd_q <= cdw_d[20:0];
      r8p_q <= r8_q[CorLat-1];
      carp_q <= carc_q[CorLat-1];
      lox_q <= lox_d;
      hix_q <= hix_d;
      loy_q <= loy_d;
      hiy_q <= hiy_d;
      carm_q <= carp_q;
      dx_q <= carm_q.zero ? carm_q.dxz : satx_d;
      dy_q <= carm_q.zero ? '0 : saty_d;
      dh_q <= carm_q.dth;
    end
  end

  assign empty_o = !vld_q[TotLat-1];
  assign delta_x_o = dx_q;
  assign delta_y_o = dy_q;
  assign delta_heading_o = dh_q;

endmodule

// ===== src/diff_drive_odometry_step.sv =====
// channel   direction  handshake            payload
// input     in         push / full          left_ticks_i, right_ticks_i, heading_i
// result    out        empty / pop          delta_x_o, delta_y_o, delta_heading_o
// config    in         cfg_we_i             cfg_idx_i, cfg_data_i (24 bit)
//
// one item per cycle sustained while results are popped; every item gives exactly one result
// the path runs through 4 front stages, one queue slot,
// an issue register, a 46-stage restoring divider for the turn radius, the
// cordic pipeline (CORDIC_ITERATIONS + 2) and 3 multiply/round stages
// reset is asynchronous and active low, clears all valid bits and pointers
// a result left waiting freezes the back pipeline; the 8-entry queue keeps
// taking items until it is full
module diff_drive_odometry_step #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] left_ticks_i,
  input  logic signed [15:0] right_ticks_i,
  input  logic signed [15:0] heading_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] delta_x_o,
  output logic signed [31:0] delta_y_o,
  output logic signed [15:0] delta_heading_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [23:0]        cfg_data_i
);
  import ddo_pkg::*;

  logic [23:0] dpt_q, ibw_q;

  logic         in_fire;
  logic         f_valid;
  mid_t         f_item;
  logic [2:0]   f_inflight;
  mid_t         q_item;
  logic         q_empty;
  logic [QAw:0] q_count;
  logic [QAw+1:0] credits;
  logic         b_ready;
  logic         issue;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpt_q <= DistPerTickRst;
      ibw_q <= InvWheelBaseRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDistPerTick: dpt_q <= cfg_data_i;
        RegInvWheelBase: ibw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // items still in the front count against queue room, so the front never stalls
  assign credits = (QAw+2)'(q_count) + (QAw+2)'(f_inflight);
  assign full = (credits >= (QAw+2)'(QDepth));
  assign in_fire = push && !full;

  // front: wheel distances and heading change
  ddo_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_fire),
    .left_ticks_i  (left_ticks_i),
    .right_ticks_i (right_ticks_i),
    .heading_i     (heading_i),
    .dpt_i         (dpt_q),
    .ibw_i         (ibw_q),
    .out_valid_o   (f_valid),
    .out_item_o    (f_item),
    .inflight_o    (f_inflight)
  );

  ddo_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (f_valid),
    .wr_item_i (f_item),
    .rd_i      (issue),
    .rd_item_o (q_item),
    .empty_o   (q_empty),
    .count_o   (q_count)
  );

  assign issue = b_ready && !q_empty;

  // back: radius divide, sine/cosine, displacement
  ddo_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (issue),
    .in_item_i       (q_item),
    .ready_o         (b_ready),
    .pop_i           (pop),
    .empty_o         (empty),
    .delta_x_o       (delta_x_o),
    .delta_y_o       (delta_y_o),
    .delta_heading_o (delta_heading_o)
  );

endmodule

// ===== src/ddo_checker.sv =====
`include "assert_macros.svh"

module ddo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [31:0] delta_x_o,
  input logic signed [31:0] delta_y_o,
  input logic signed [15:0] delta_heading_o
);

  // reset leaves no result and room for items
  `CHK_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> empty && !full)

  // a straight move has no sideways part
  `CHK_ASSERT(a_straight, clk_i, rst_ni, !empty && delta_heading_o == 16'sd0 |-> delta_y_o == 32'sd0)

  // a result that is not taken stays put
  `CHK_ASSERT(a_hold, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(delta_x_o) && $stable(delta_y_o) && $stable(delta_heading_o))

  // a stalled push sees a known (never X) full flag
  `CHK_ASSERT(a_full_push, clk_i, rst_ni, push && full |-> !$isunknown(full))

endmodule

bind diff_drive_odometry_step ddo_checker u_chk (.*);
